>>> hdl/cprs_pkg.sv
package cprs_pkg;

  localparam int unsigned DEV_W  = 8;
  localparam int unsigned CB_W   = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 8;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 8'd128;

  typedef enum logic [1:0] {
    ACT_ENQ_CMD  = 2'd0,
    ACT_ENQ_POLL = 2'd1,
    ACT_REQUEUE  = 2'd2,
    ACT_TAKE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CMD_PUSH,
    OP_POLL_PUSH,
    OP_REQUEUE,
    OP_CMD_POP,
    OP_POLL_POP
  } op_t;

  typedef struct packed {
    logic [DEV_W-1:0]  target_dev;
    logic [CB_W-1:0]   handler_tag;
    logic [WORD_W-1:0] request_word;
  } entry_t;

  typedef struct packed {
    logic    capture;
    op_t     op;
    logic    load_imm;
    status_t imm_status;
    logic    load_rd;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    cmd_full;
    logic    poll_full;
    logic    too_long;
    logic    cmd_avail;
    logic    poll_avail;
  } dp_status_t;

endpackage

>>> hdl/cprs_ifs.sv
interface cprs_in_if;
  import cprs_pkg::*;

  logic                valid;
  logic                ready;
  action_t             action;
  logic [DEV_W-1:0]    target_dev;
  logic [CB_W-1:0]     handler_tag;
  logic [WORD_W-1:0]   request_word;
  logic [LEN_W-1:0]    request_length;

  modport source (
    output valid, action, target_dev, handler_tag, request_word, request_length,
    input  ready
  );
  modport sink (
    input  valid, action, target_dev, handler_tag, request_word, request_length,
    output ready
  );
endinterface

interface cprs_out_if;
  import cprs_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [DEV_W-1:0]    out_target_dev;
  logic [CB_W-1:0]     out_handler_tag;
  logic [WORD_W-1:0]   out_request_word;
  logic                out_is_poll;

  modport source (
    output valid, status, out_target_dev, out_handler_tag, out_request_word, out_is_poll,
    input  ready
  );
  modport sink (
    input  valid, status, out_target_dev, out_handler_tag, out_request_word, out_is_poll,
    output ready
  );
endinterface

>>> hdl/command_poll_request_scheduler_unit.sv
// channel   dir  handshake      payload
// in_req    in   valid/ready    action, target_dev, handler_tag, request_word, request_length
// out_rsp   out  valid/ready    status, out_target_dev, out_handler_tag, out_request_word,
//                               out_is_poll
// cfg       in   cfg_we         cfg_wdata (length limit; lengths >= limit rejected)
//
// one request at a time: enqueue, requeue and an empty take go through accept, execute
// and respond, out_rsp.valid rising in the respond state after execute
// an issuing take adds a read state between execute and respond, since the command or poll
// store is read through a registered memory port
// out_rsp.ready low holds the result and keeps in_req.ready low
// reset (synchronous, rst_n low) empties both queues, ends the poll scan, limit = 128
module command_poll_request_scheduler_unit #(
  parameter int unsigned CMD_DEPTH  = 16,
  parameter int unsigned POLL_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cprs_in_if.sink                    in_req,
  cprs_out_if.source                 out_rsp,
  input  logic                       cfg_we,
  input  logic [cprs_pkg::LEN_W-1:0] cfg_wdata
);
  import cprs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  cprs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  cprs_datapath #(
    .CMD_DEPTH  (CMD_DEPTH),
    .POLL_DEPTH (POLL_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_req.action),
    .in_target_dev     (in_req.target_dev),
    .in_handler_tag    (in_req.handler_tag),
    .in_request_word   (in_req.request_word),
    .in_request_length (in_req.request_length),
    .dp_cmd            (dp_cmd),
    .dp_status         (dp_status),
    .out_status        (out_rsp.status),
    .out_target_dev    (out_rsp.out_target_dev),
    .out_handler_tag   (out_rsp.out_handler_tag),
    .out_request_word  (out_rsp.out_request_word),
    .out_is_poll       (out_rsp.out_is_poll)
  );

endmodule

>>> hdl/cprs_ctrl.sv
module cprs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cprs_pkg::dp_status_t dp_status,
  output cprs_pkg::dp_cmd_t    dp_cmd
);
  import cprs_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  op_t     dec_op;
  status_t dec_status;

  // decide what the captured request does against the current queue state
  always_comb begin
    dec_op     = OP_NONE;
    dec_status = ST_OK;
    case (dp_status.action)
      ACT_ENQ_CMD: begin
        if (dp_status.cmd_full) begin
          dec_status = ST_FULL;
        end else if (dp_status.too_long) begin
          dec_status = ST_TOO_LONG;
        end else begin
          dec_op = OP_CMD_PUSH;
        end
      end
      ACT_ENQ_POLL: begin
        if (dp_status.poll_full) begin
          dec_status = ST_FULL;
        end else if (dp_status.too_long) begin
          dec_status = ST_TOO_LONG;
        end else begin
          dec_op = OP_POLL_PUSH;
        end
      end
      ACT_REQUEUE: begin
        dec_op = OP_REQUEUE;
      end
      ACT_TAKE: begin
        if (dp_status.cmd_avail) begin
          dec_op = OP_CMD_POP;
        end else if (dp_status.poll_avail) begin
          dec_op = OP_POLL_POP;
        end else begin
          dec_status = ST_EMPTY;
        end
      end
      default: begin
        dec_op     = OP_NONE;
        dec_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (dec_op == OP_CMD_POP || dec_op == OP_POLL_POP) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    dp_cmd.capture    = 1'b0;
    dp_cmd.op         = OP_NONE;
    dp_cmd.load_imm   = 1'b0;
    dp_cmd.imm_status = ST_OK;
    dp_cmd.load_rd    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready       = 1'b1;
        dp_cmd.capture = in_valid;
      end
      S_EXEC: begin
        dp_cmd.op         = dec_op;
        dp_cmd.imm_status = dec_status;
        dp_cmd.load_imm   = !(dec_op == OP_CMD_POP || dec_op == OP_POLL_POP);
      end
      S_READ: begin
        dp_cmd.load_rd = 1'b1;
      end
      S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/cprs_datapath.sv
module cprs_datapath #(
  parameter int unsigned CMD_DEPTH  = 16,
  parameter int unsigned POLL_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cprs_pkg::LEN_W-1:0]    cfg_wdata,
  input  cprs_pkg::action_t             in_action,
  input  logic [cprs_pkg::DEV_W-1:0]    in_target_dev,
  input  logic [cprs_pkg::CB_W-1:0]     in_handler_tag,
  input  logic [cprs_pkg::WORD_W-1:0]   in_request_word,
  input  logic [cprs_pkg::LEN_W-1:0]    in_request_length,
  input  cprs_pkg::dp_cmd_t             dp_cmd,
  output cprs_pkg::dp_status_t          dp_status,
  output cprs_pkg::status_t             out_status,
  output logic [cprs_pkg::DEV_W-1:0]    out_target_dev,
  output logic [cprs_pkg::CB_W-1:0]     out_handler_tag,
  output logic [cprs_pkg::WORD_W-1:0]   out_request_word,
  output logic                          out_is_poll
);
  import cprs_pkg::*;

  localparam int unsigned CMD_AW  = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CW  = $clog2(CMD_DEPTH + 1);
  localparam int unsigned POLL_AW = $clog2(POLL_DEPTH);
  localparam int unsigned POLL_CW = $clog2(POLL_DEPTH + 1);

  localparam logic [CMD_AW-1:0]  CMD_LAST  = CMD_AW'(CMD_DEPTH - 1);
  localparam logic [CMD_CW-1:0]  CMD_FULL  = CMD_CW'(CMD_DEPTH);
  localparam logic [POLL_CW-1:0] POLL_FULL = POLL_CW'(POLL_DEPTH);

  // captured request
  action_t          action_r;
  entry_t           entry_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] max_len_r;

  // command fifo
  entry_t             cmd_mem [CMD_DEPTH];
  entry_t             cmd_rd_r;
  logic [CMD_AW-1:0]  cmd_head_r, cmd_head_nxt;
  logic [CMD_AW-1:0]  cmd_tail_r, cmd_tail_nxt;
  logic [CMD_CW-1:0]  cmd_count_r, cmd_count_nxt;

  // poll list
  entry_t             poll_mem [POLL_DEPTH];
  entry_t             poll_rd_r;
  logic [POLL_CW-1:0] poll_count_r, poll_count_nxt;
  logic [POLL_AW-1:0] poll_cursor_r, poll_cursor_nxt;
  logic               scan_done_r, scan_done_nxt;
  logic [POLL_CW-1:0] cursor_inc;

  logic               src_poll_r;

  status_t            out_status_r;
  entry_t             out_entry_r;
  logic               out_is_poll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      action_r              <= in_action;
      entry_r.target_dev    <= in_target_dev;
      entry_r.handler_tag   <= in_handler_tag;
      entry_r.request_word  <= in_request_word;
      len_r                 <= in_request_length;
    end
  end

  assign dp_status.action     = action_r;
  assign dp_status.cmd_full   = (cmd_count_r == CMD_FULL);
  assign dp_status.poll_full  = (poll_count_r == POLL_FULL);
  assign dp_status.too_long   = (len_r >= max_len_r);
  assign dp_status.cmd_avail  = (cmd_count_r != '0);
  assign dp_status.poll_avail = !scan_done_r && (POLL_CW'(poll_cursor_r) < poll_count_r);

  assign cursor_inc = POLL_CW'(poll_cursor_r) + POLL_CW'(1);

  always_comb begin
    cmd_head_nxt    = cmd_head_r;
    cmd_tail_nxt    = cmd_tail_r;
    cmd_count_nxt   = cmd_count_r;
    poll_count_nxt  = poll_count_r;
    poll_cursor_nxt = poll_cursor_r;
    scan_done_nxt   = scan_done_r;
    case (dp_cmd.op)
      OP_CMD_PUSH: begin
        cmd_tail_nxt  = (cmd_tail_r == CMD_LAST) ? '0 : cmd_tail_r + CMD_AW'(1);
        cmd_count_nxt = cmd_count_r + CMD_CW'(1);
      end
      OP_POLL_PUSH: begin
        poll_count_nxt = poll_count_r + POLL_CW'(1);
      end
      OP_REQUEUE: begin
        if (scan_done_r && poll_count_r != '0) begin
          poll_cursor_nxt = '0;
          scan_done_nxt   = 1'b0;
        end
      end
      OP_CMD_POP: begin
        cmd_head_nxt  = (cmd_head_r == CMD_LAST) ? '0 : cmd_head_r + CMD_AW'(1);
        cmd_count_nxt = cmd_count_r - CMD_CW'(1);
      end
      OP_POLL_POP: begin
        // past the last poll the scan ends until the next requeue
        if (cursor_inc >= poll_count_r) begin
          poll_cursor_nxt = '0;
          scan_done_nxt   = 1'b1;
        end else begin
          poll_cursor_nxt = cursor_inc[POLL_AW-1:0];
        end
      end
      default: begin
        cmd_head_nxt = cmd_head_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_head_r    <= '0;
      cmd_tail_r    <= '0;
      cmd_count_r   <= '0;
      poll_count_r  <= '0;
      poll_cursor_r <= '0;
      scan_done_r   <= 1'b1;
    end else begin
      cmd_head_r    <= cmd_head_nxt;
      cmd_tail_r    <= cmd_tail_nxt;
      cmd_count_r   <= cmd_count_nxt;
      poll_count_r  <= poll_count_nxt;
      poll_cursor_r <= poll_cursor_nxt;
      scan_done_r   <= scan_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_CMD_PUSH) begin
      cmd_mem[cmd_tail_r] <= entry_r;
    end
    if (dp_cmd.op == OP_CMD_POP) begin
      cmd_rd_r <= cmd_mem[cmd_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_POLL_PUSH) begin
      poll_mem[poll_count_r[POLL_AW-1:0]] <= entry_r;
    end
    if (dp_cmd.op == OP_POLL_POP) begin
      poll_rd_r <= poll_mem[poll_cursor_r];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_CMD_POP || dp_cmd.op == OP_POLL_POP) begin
      src_poll_r <= (dp_cmd.op == OP_POLL_POP);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_imm) begin
      out_status_r  <= dp_cmd.imm_status;
      out_entry_r   <= '0;
      out_is_poll_r <= 1'b0;
    end else if (dp_cmd.load_rd) begin
      out_status_r  <= ST_OK;
      out_entry_r   <= src_poll_r ? poll_rd_r : cmd_rd_r;
      out_is_poll_r <= src_poll_r;
    end
  end

  assign out_status       = out_status_r;
  assign out_target_dev   = out_entry_r.target_dev;
  assign out_handler_tag  = out_entry_r.handler_tag;
  assign out_request_word = out_entry_r.request_word;
  assign out_is_poll      = out_is_poll_r;

endmodule
